>>> rtl/llh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency log2 histogram package
// Shared item kinds, the counter count and the lane sample type.
// ----------------------------------------------------------------------------
package llh_pkg;

    localparam logic [1:0] KIND_RECORD    = 2'd0;
    localparam logic [1:0] KIND_STAGE_Q   = 2'd1;
    localparam logic [1:0] KIND_COUNTER_Q = 2'd2;
    localparam logic [1:0] KIND_CLEAR     = 2'd3;

    localparam int COUNTERS = 11;

    typedef struct packed {
        logic        valid;
        logic [63:0] duration;
    } sample_t;

endpackage

>>> rtl/llh_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency log2 histogram stage lane
// Holds the total, sample count and bucket memory of one stage and walks the
// buckets to answer a percentile query.
// ----------------------------------------------------------------------------
module llh_lane #(
    parameter int BUCKETS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 clr_start,
    output logic                 clr_busy,
    input  llh_pkg::sample_t     sample,
    input  logic                 q_start,
    input  logic [70:0]          q_target,
    output logic                 q_done,
    output logic [63:0]          q_bound,
    output logic [63:0]          total,
    output logic [63:0]          count
);
    localparam int BW = $clog2(BUCKETS);

    logic [63:0]   mem [BUCKETS];
    logic [63:0]   total_reg;
    logic [63:0]   count_reg;
    logic [BW:0]   clr_idx_reg;
    logic          clr_reg;
    logic [BW-1:0] bkt;
    logic [63:0]   d;

    // Update pipeline: read then write back.
    logic          upd_reg;
    logic [BW-1:0] upd_idx_reg;
    logic [63:0]   rd_reg;

    // Query walk. The threshold is n*p; a bucket is reached once 100*seen meets it.
    logic          qrun_reg;
    logic          qrd_reg;
    logic [BW:0]   qidx_reg;
    logic [63:0]   seen_reg;
    logic [70:0]   target_reg;
    logic          qdone_reg;
    logic [63:0]   qbound_reg;
    logic [63:0]   seen_next;
    logic [70:0]   seen_x100;

    always_comb begin
        d   = sample.duration;
        bkt = '0;
        for (int i = 1; i < BUCKETS; i++) begin
            if ((d >> i) != '0) begin
                bkt = BW'(i);
            end
        end
    end

    assign seen_next = seen_reg + rd_reg;
    assign seen_x100 = {1'b0, seen_next, 6'd0} + {2'b0, seen_next, 5'd0}
                       + {5'd0, seen_next, 2'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn || clr_start) begin
            clr_reg     <= 1'b1;
            clr_idx_reg <= '0;
            total_reg   <= '0;
            count_reg   <= '0;
            upd_reg     <= 1'b0;
            qrun_reg    <= 1'b0;
            qrd_reg     <= 1'b0;
            qdone_reg   <= 1'b0;
        end else begin
            qdone_reg <= 1'b0;
            if (clr_reg) begin
                mem[clr_idx_reg[BW-1:0]] <= '0;
                if (clr_idx_reg == (BW+1)'(BUCKETS - 1)) begin
                    clr_reg <= 1'b0;
                end
                clr_idx_reg <= clr_idx_reg + (BW+1)'(1);
            end else begin
                upd_reg <= sample.valid;
                if (sample.valid) begin
                    total_reg   <= total_reg + d;
                    count_reg   <= count_reg + 64'd1;
                    upd_idx_reg <= bkt;
                    if (upd_reg && upd_idx_reg == bkt) begin
                        rd_reg <= rd_reg + 64'd1;
                    end else begin
                        rd_reg <= mem[bkt];
                    end
                end
                if (upd_reg) begin
                    mem[upd_idx_reg] <= rd_reg + 64'd1;
                end
                if (q_start) begin
                    qrun_reg   <= 1'b1;
                    qrd_reg    <= 1'b0;
                    qidx_reg   <= '0;
                    seen_reg   <= '0;
                    target_reg <= q_target;
                end else if (qrun_reg) begin
                    if (!qrd_reg) begin
                        rd_reg  <= mem[qidx_reg[BW-1:0]];
                        qrd_reg <= 1'b1;
                    end else begin
                        qrd_reg  <= 1'b0;
                        seen_reg <= seen_next;
                        if ((seen_x100 >= target_reg) && (seen_next != '0)) begin
                            qrun_reg  <= 1'b0;
                            qdone_reg <= 1'b1;
                            if (qidx_reg >= (BW+1)'(BUCKETS - 1) || qidx_reg >= (BW+1)'(63)) begin
                                qbound_reg <= '1;
                            end else begin
                                qbound_reg <= (64'd1 << (qidx_reg + (BW+1)'(1))) - 64'd1;
                            end
                        end else if (qidx_reg == (BW+1)'(BUCKETS - 1)) begin
                            qrun_reg   <= 1'b0;
                            qdone_reg  <= 1'b1;
                            qbound_reg <= '1;
                        end
                        qidx_reg <= qidx_reg + (BW+1)'(1);
                    end
                end
            end
        end
    end

    assign clr_busy = clr_reg;
    assign q_done   = qdone_reg;
    assign q_bound  = qbound_reg;
    assign total    = total_reg;
    assign count    = count_reg;
endmodule

>>> rtl/llh_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Latency log2 histogram divider
// Radix-2 restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module llh_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [63:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);
    logic [63:0] q_reg;
    logic [64:0] r_reg;
    logic [63:0] dv_reg;
    logic [6:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic [64:0] trial;

    assign trial = {r_reg[63:0], q_reg[63]} - {1'b0, dv_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                q_reg   <= dividend;
                r_reg   <= '0;
                dv_reg  <= divisor;
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end else if (run_reg) begin
                if (!trial[64]) begin
                    r_reg <= trial;
                    q_reg <= {q_reg[62:0], 1'b1};
                end else begin
                    r_reg <= {r_reg[63:0], q_reg[63]};
                    q_reg <= {q_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule

>>> rtl/latency_log2_histogram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// A record is taken when accepted; a clear holds the input off while each lane
// sweeps its bucket memory. A counter query result is offered in the cycle after
// the item is accepted, a stage query result once both the bucket walk and the
// average divider are done, or straight from ST_TGT when the stage holds no
// samples. Throughput is one item at a time.
// Reset clears all stores and sweeps the bucket memories.
// ----------------------------------------------------------------------------
module latency_log2_histogram #(
    parameter int BUCKETS = 64,
    parameter int STAGES  = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [63:0] s_start_time,
    input  logic [63:0] s_lookup_done_time,
    input  logic [63:0] s_backing_done_time,
    input  logic [63:0] s_mapping_done_time,
    input  logic [63:0] s_end_time,
    input  logic [4:0]  s_event_flags,
    input  logic [1:0]  s_object_class,
    input  logic [2:0]  s_query_stage,
    input  logic [6:0]  s_query_percentile,
    input  logic [3:0]  s_query_counter,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_counter_value,
    output logic [63:0] m_quantile_bound,
    output logic [63:0] m_sample_count,
    output logic [63:0] m_time_total,
    output logic [63:0] m_time_average
);
    localparam int SW = (STAGES > 1) ? $clog2(STAGES) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_TGT  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]  state_reg;
    logic [63:0] cnt_reg [llh_pkg::COUNTERS];
    logic        acc;
    logic        clr_start;
    logic [STAGES-1:0] busy;
    logic [STAGES-1:0] qdone;
    logic [63:0] bound [STAGES];
    logic [63:0] tot [STAGES];
    logic [63:0] num [STAGES];
    llh_pkg::sample_t smp [STAGES];
    logic [63:0] dur [5];
    logic [4:0]  ok;
    logic [SW-1:0] sel_reg;
    logic [63:0] n_reg, t_reg;
    logic [6:0]  p_reg;
    logic [6:0]  pct;
    logic [70:0] np;
    logic [STAGES-1:0] qstart;
    logic        wq_reg, wd_reg;
    logic        div_start, div_done;
    logic [63:0] quot;
    logic [63:0] o_cnt_reg, o_b_reg, o_n_reg, o_t_reg, o_a_reg;
    logic        o_v_reg;

    assign s_ready = (state_reg == ST_IDLE) && !o_v_reg && (busy == '0);
    assign acc     = s_valid && s_ready;
    assign clr_start = acc && s_kind == llh_pkg::KIND_CLEAR;

    always_comb begin
        dur[0] = s_lookup_done_time - s_start_time;
        dur[1] = s_backing_done_time - s_lookup_done_time;
        dur[2] = s_mapping_done_time - s_backing_done_time;
        dur[3] = s_end_time - s_mapping_done_time;
        dur[4] = s_end_time - s_start_time;
        ok[0] = s_lookup_done_time >= s_start_time;
        ok[1] = s_backing_done_time >= s_lookup_done_time && s_backing_done_time != '0;
        ok[2] = s_mapping_done_time >= s_backing_done_time && s_mapping_done_time != '0;
        ok[3] = s_end_time >= s_mapping_done_time && s_mapping_done_time != '0;
        ok[4] = s_end_time >= s_start_time;
    end

    genvar g;
    generate
        for (g = 0; g < STAGES; g++) begin : g_lane
            if (g < 5) begin : g_on
                assign smp[g].valid = acc && s_kind == llh_pkg::KIND_RECORD
                                      && s_start_time != '0 && ok[g];
                assign smp[g].duration = dur[g];
            end else begin : g_off
                assign smp[g].valid = 1'b0;
                assign smp[g].duration = '0;
            end
            llh_lane #(.BUCKETS(BUCKETS)) u_lane (
                .aclk(aclk), .aresetn(aresetn), .clr_start(clr_start),
                .clr_busy(busy[g]), .sample(smp[g]), .q_start(qstart[g]),
                .q_target(np), .q_done(qdone[g]), .q_bound(bound[g]),
                .total(tot[g]), .count(num[g])
            );
            assign qstart[g] = (state_reg == ST_TGT) && n_reg != '0
                               && sel_reg == SW'(g);
        end
    endgenerate

    // The lanes compare 100 times the running sample count against n*p, which
    // gives the exact ceil(n*p/100) target without a division.
    assign pct = (p_reg > 7'd100) ? 7'd100 : p_reg;
    assign np  = {7'd0, n_reg} * {64'd0, pct};

    assign div_start = (state_reg == ST_TGT) && n_reg != '0;

    llh_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(t_reg),
        .divisor(n_reg), .done(div_done), .quotient(quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            o_v_reg   <= 1'b0;
            for (int i = 0; i < llh_pkg::COUNTERS; i++) cnt_reg[i] <= '0;
        end else begin
            if (o_v_reg && m_ready) begin
                o_v_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (acc) begin
                        case (s_kind)
                            llh_pkg::KIND_CLEAR: begin
                                for (int i = 0; i < llh_pkg::COUNTERS; i++) cnt_reg[i] <= '0;
                            end
                            llh_pkg::KIND_RECORD: begin
                                if (s_start_time != '0) begin
                                    cnt_reg[0] <= cnt_reg[0] + 64'd1;
                                    if (s_event_flags[0]) cnt_reg[1] <= cnt_reg[1] + 64'd1;
                                    else cnt_reg[2] <= cnt_reg[2] + 64'd1;
                                    if (s_event_flags[1]) cnt_reg[4] <= cnt_reg[4] + 64'd1;
                                    else cnt_reg[3] <= cnt_reg[3] + 64'd1;
                                    if (s_object_class == 2'd0) cnt_reg[5] <= cnt_reg[5] + 64'd1;
                                    if (s_object_class == 2'd1) cnt_reg[6] <= cnt_reg[6] + 64'd1;
                                    if (s_object_class == 2'd2) cnt_reg[7] <= cnt_reg[7] + 64'd1;
                                    if (s_event_flags[2]) cnt_reg[8] <= cnt_reg[8] + 64'd1;
                                    if (s_event_flags[3]) cnt_reg[9] <= cnt_reg[9] + 64'd1;
                                    if (s_event_flags[4]) cnt_reg[10] <= cnt_reg[10] + 64'd1;
                                end
                            end
                            llh_pkg::KIND_COUNTER_Q: begin
                                o_cnt_reg <= (s_query_counter < 4'(llh_pkg::COUNTERS))
                                             ? cnt_reg[s_query_counter] : '0;
                                o_b_reg <= '0; o_n_reg <= '0; o_t_reg <= '0; o_a_reg <= '0;
                                o_v_reg <= 1'b1;
                            end
                            default: begin
                                o_cnt_reg <= '0; o_b_reg <= '0; o_n_reg <= '0;
                                o_t_reg <= '0; o_a_reg <= '0;
                                if (32'(s_query_stage) < STAGES) begin
                                    sel_reg   <= SW'(s_query_stage);
                                    n_reg     <= num[SW'(s_query_stage)];
                                    t_reg     <= tot[SW'(s_query_stage)];
                                    p_reg     <= s_query_percentile;
                                    state_reg <= ST_TGT;
                                end else begin
                                    o_v_reg <= 1'b1;
                                end
                            end
                        endcase
                    end
                end
                ST_TGT: begin
                    o_n_reg <= n_reg;
                    o_t_reg <= t_reg;
                    if (n_reg == '0) begin
                        o_v_reg   <= 1'b1;
                        state_reg <= ST_IDLE;
                    end else begin
                        wq_reg    <= 1'b0;
                        wd_reg    <= 1'b0;
                        state_reg <= ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (qdone[sel_reg]) begin
                        o_b_reg <= bound[sel_reg];
                        wq_reg  <= 1'b1;
                    end
                    if (div_done) begin
                        o_a_reg <= quot;
                        wd_reg  <= 1'b1;
                    end
                    if ((wq_reg || qdone[sel_reg]) && (wd_reg || div_done)) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    o_v_reg   <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid          = o_v_reg;
    assign m_counter_value  = o_cnt_reg;
    assign m_quantile_bound = o_b_reg;
    assign m_sample_count   = o_n_reg;
    assign m_time_total     = o_t_reg;
    assign m_time_average   = o_a_reg;
endmodule
